/* rtl/affine_matrix_decompose_top_assert.svh */
// Assertion macros for the affine matrix decomposition block.
`ifndef AFFINE_MATRIX_DECOMPOSE_TOP_ASSERT_SVH
`define AFFINE_MATRIX_DECOMPOSE_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define AMD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in affine matrix decompose");

// Check a consequence in the cycle after its antecedent.
`define AMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in affine matrix decompose");

`endif

/* rtl/amd_pkg.sv */
// Package: types, constants and step functions of the affine matrix decomposition.
`default_nettype none
package amd_pkg;

   localparam int Lanes      = 9;
   localparam int Cols       = 3;
   localparam int Root1Steps = 32;
   localparam int Root2Steps = 31;
   localparam int QuoBits    = 31;

   localparam logic [63:0] Q30One = 64'd1 << 30;
   localparam logic signed [17:0] QuatOne = 18'sd65536;
   localparam logic [30:0] ScaleMax = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [63:0] v;
      logic [63:0] r;
   } root_type;

   typedef struct packed {
      logic [62:0] rem;
      logic [30:0] q;
   } quo_type;

   typedef struct packed {
      logic [2:0][31:0] t;
      logic [2:0][31:0] len;
   } side_type;

   typedef enum logic [1:0] {SelX, SelY, SelZ, SelW} sel_type;

   function automatic logic [31:0] mag32(logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   // One digit of the bitwise integer square root, trial bit 4^i.
   function automatic root_type root_step(root_type s, logic [4:0] i);
      logic [63:0] bitv;
      logic [63:0] trial;
      root_type    n;
      bitv  = 64'd1 << {i, 1'b0};
      trial = s.r + bitv;
      if (s.v >= trial) begin
         n.v = s.v - trial;
         n.r = (s.r >> 1) + bitv;
      end else begin
         n.v = s.v;
         n.r = s.r >> 1;
      end
      return n;
   endfunction

   // One quotient bit of restoring division, divisor shifted by k.
   function automatic quo_type quo_step(quo_type s, logic [31:0] d, logic [4:0] k);
      logic [62:0] dsh;
      quo_type     n;
      dsh = {31'd0, d} << k;
      n   = s;
      if (s.rem >= dsh) begin
         n.rem  = s.rem - dsh;
         n.q[k] = 1'b1;
      end
      return n;
   endfunction

   // Q.30 sign and magnitude to Q1.16, round half away from zero.
   function automatic logic [17:0] q30_round(logic neg, logic [30:0] m);
      logic [31:0] sum;
      sum = {1'b0, m} + 32'd8192;
      return neg ? (18'd0 - {1'b0, sum[30:14]}) : {1'b0, sum[30:14]};
   endfunction

endpackage
`default_nettype wire

/* rtl/amd_if.sv */
// Channel interfaces: matrix request and decomposition response.
`default_nettype none
interface amd_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] c0_x, c0_y, c0_z;
   logic signed [31:0] c1_x, c1_y, c1_z;
   logic signed [31:0] c2_x, c2_y, c2_z;
   logic signed [31:0] t_x, t_y, t_z;
   modport source (output valid, c0_x, c0_y, c0_z, c1_x, c1_y, c1_z,
                   c2_x, c2_y, c2_z, t_x, t_y, t_z, input ready);
   modport sink (input valid, c0_x, c0_y, c0_z, c1_x, c1_y, c1_z,
                 c2_x, c2_y, c2_z, t_x, t_y, t_z, output ready);
endinterface

interface amd_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] pos_x, pos_y, pos_z;
   logic signed [17:0] quat_x, quat_y, quat_z, quat_w;
   logic [30:0] scale_x, scale_y, scale_z;
   logic degenerate;
   modport source (output valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
                   scale_x, scale_y, scale_z, degenerate, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
                 scale_x, scale_y, scale_z, degenerate, output ready);
endinterface
`default_nettype wire

/* rtl/affine_matrix_decompose_top.sv */
// Top level: pipelined translation, scale and quaternion decomposition of an affine matrix.
//
// Usage:
//  - req_chan carries one matrix transaction: three basis columns and the translation
//    column, signed Q16.16. rsp_chan carries position, Q1.16 quaternion, saturated
//    Q16.16 scale and a degenerate flag (any zero column gives the identity quaternion).
//  - Throughput: one transaction per cycle while rsp_chan does not stall. 130 register
//    stages: squares, sum, a 32-stage square root, a 31-stage divider for the nine
//    normalized entries, trace and select stages, a 31-stage square root for the
//    largest component, a 31-stage divider for the other three, and the output register.
//  - Stall: while rsp_chan holds a result that is not taken, the whole pipeline holds;
//    req_chan.ready is low only then. Empty stages hold as well, so bubbles stay put.
//  - Reset (synchronous, active high) clears every stage valid bit; data registers
//    are not reset.
`default_nettype none
`include "affine_matrix_decompose_top_assert.svh"
module affine_matrix_decompose_top import amd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   amd_req_if.sink     req_chan,
   amd_rsp_if.source   rsp_chan
);

   // Stage map.
   localparam int StSq       = 0;
   localparam int StSum      = 1;
   localparam int StRt1First = 2;
   localparam int StRt1Last  = StRt1First + Root1Steps - 1;
   localparam int StDv1First = StRt1Last + 1;
   localparam int StDv1Last  = StDv1First + QuoBits - 1;
   localparam int StTrace    = StDv1Last + 1;
   localparam int StSelect   = StTrace + 1;
   localparam int StRt2First = StSelect + 1;
   localparam int StRt2Last  = StRt2First + Root2Steps - 1;
   localparam int StDv2First = StRt2Last + 1;
   localparam int StDv2Last  = StDv2First + QuoBits - 1;
   localparam int StOut      = StDv2Last + 1;
   localparam int NStage     = StOut + 1;

   logic [NStage-1:0] vld_ff;
   logic              adv;

   logic [31:0]        col_in [Lanes];
   logic [31:0]        col_ff [StSq:StRt1Last][Lanes];
   logic [63:0]        sqr_ff [Lanes];
   side_type           side_ff [StSq:StDv2Last];
   root_type           rt1_ff [StSum:StRt1Last][Cols];
   quo_type            dv1_ff [StDv1First:StDv1Last][Lanes];
   logic               neg1_ff [StDv1First:StDv1Last][Lanes];
   logic signed [32:0] mm [Lanes];
   logic signed [32:0] tr_ff [4];
   logic signed [32:0] dd_ff [6];
   logic signed [32:0] big;
   sel_type            sel;
   logic signed [32:0] dr_in [3];
   sel_type            sel_ff [StSelect:StDv2Last];
   logic signed [32:0] dr_ff [StSelect:StRt2Last][3];
   root_type           rt2_ff [StSelect:StRt2Last];
   quo_type            dv2_ff [StDv2First:StDv2Last][3];
   logic               neg2_ff [StDv2First:StDv2Last][3];
   logic [30:0]        bv_ff [StDv2First:StDv2Last];

   logic [17:0]        qb, qa0, qa1, qa2;
   logic [17:0]        qx_in, qy_in, qz_in, qw_in;
   logic               degen_in;
   logic [17:0]        qx_ff, qy_ff, qz_ff, qw_ff;
   logic [2:0][31:0]   pos_ff;
   logic [2:0][30:0]   scale_ff;
   logic               degen_ff;

   // Whole pipeline advances unless a finished result is held by the receiver.
   assign adv            = !vld_ff[StOut] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = vld_ff[StOut];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NStage-2:0], req_chan.valid};
      end
   end

   assign col_in[0] = req_chan.c0_x;
   assign col_in[1] = req_chan.c0_y;
   assign col_in[2] = req_chan.c0_z;
   assign col_in[3] = req_chan.c1_x;
   assign col_in[4] = req_chan.c1_y;
   assign col_in[5] = req_chan.c1_z;
   assign col_in[6] = req_chan.c2_x;
   assign col_in[7] = req_chan.c2_y;
   assign col_in[8] = req_chan.c2_z;

   // Square every entry; capture translation.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < Lanes; l++) begin
            col_ff[StSq][l] <= col_in[l];
            sqr_ff[l]       <= mag32(col_in[l]) * mag32(col_in[l]);
         end
         side_ff[StSq].t   <= {req_chan.t_z, req_chan.t_y, req_chan.t_x};
         side_ff[StSq].len <= '0;
      end
   end

   // Sum squares per column into the root radicand.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < Cols; c++) begin
            rt1_ff[StSum][c].v <= sqr_ff[Cols*c] + sqr_ff[Cols*c+1] + sqr_ff[Cols*c+2];
            rt1_ff[StSum][c].r <= '0;
         end
      end
   end

   // Carry translation and lengths down the pipe; latch lengths when the root is done.
   for (genvar s = StSq + 1; s <= StDv2Last; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[s].t <= side_ff[s-1].t;
            if (s == StDv1First) begin
               for (int c = 0; c < Cols; c++) begin
                  side_ff[s].len[c] <= rt1_ff[StRt1Last][c].r[31:0];
               end
            end else begin
               side_ff[s].len <= side_ff[s-1].len;
            end
         end
      end
   end

   for (genvar s = StSq + 1; s <= StRt1Last; s++) begin : g_col
      always_ff @(posedge clock) begin
         if (adv) begin
            col_ff[s] <= col_ff[s-1];
         end
      end
   end

   // Column length square root, one result bit per stage.
   for (genvar s = StRt1First; s <= StRt1Last; s++) begin : g_rt1
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int c = 0; c < Cols; c++) begin
               rt1_ff[s][c] <= root_step(rt1_ff[s-1][c], 5'(Root1Steps - 1 - (s - StRt1First)));
            end
         end
      end
   end

   // Normalize entries: |col| * 2^30 / len, one quotient bit per stage.
   for (genvar s = StDv1First; s <= StDv1Last; s++) begin : g_dv1
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < Lanes; l++) begin
               if (s == StDv1First) begin
                  dv1_ff[s][l]  <= quo_step('{rem: {1'b0, mag32(col_ff[StRt1Last][l]), 30'd0},
                                              q: '0},
                                            rt1_ff[StRt1Last][l/Cols].r[31:0],
                                            5'(QuoBits - 1));
                  neg1_ff[s][l] <= col_ff[StRt1Last][l][31];
               end else begin
                  dv1_ff[s][l]  <= quo_step(dv1_ff[s-1][l], side_ff[s-1].len[l/Cols],
                                            5'(QuoBits - 1 - (s - StDv1First)));
                  neg1_ff[s][l] <= neg1_ff[s-1][l];
               end
            end
         end
      end
   end

   // Signed normalized entries, m[c][r] at lane 3c+r.
   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         mm[l] = neg1_ff[StDv1Last][l] ? (33'sd0 - signed'({2'b0, dv1_ff[StDv1Last][l].q}))
                                       : signed'({2'b0, dv1_ff[StDv1Last][l].q});
      end
   end

   // Trace terms and off-diagonal sums and differences.
   always_ff @(posedge clock) begin
      if (adv) begin
         tr_ff[SelX] <= mm[0] - mm[4] - mm[8];
         tr_ff[SelY] <= mm[4] - mm[0] - mm[8];
         tr_ff[SelZ] <= mm[8] - mm[0] - mm[4];
         tr_ff[SelW] <= mm[0] + mm[4] + mm[8];
         dd_ff[0]    <= mm[5] - mm[7];
         dd_ff[1]    <= mm[6] - mm[2];
         dd_ff[2]    <= mm[1] - mm[3];
         dd_ff[3]    <= mm[1] + mm[3];
         dd_ff[4]    <= mm[6] + mm[2];
         dd_ff[5]    <= mm[5] + mm[7];
      end
   end

   // Pick the largest term; ties keep the earlier choice (w, then x, y, z).
   always_comb begin
      big = tr_ff[SelW];
      sel = SelW;
      if (tr_ff[SelX] > big) begin
         big = tr_ff[SelX];
         sel = SelX;
      end
      if (tr_ff[SelY] > big) begin
         big = tr_ff[SelY];
         sel = SelY;
      end
      if (tr_ff[SelZ] > big) begin
         big = tr_ff[SelZ];
         sel = SelZ;
      end
      // Route the first numerator to w (or to x when w is the largest).
      unique case (sel)
         SelW: begin
            dr_in[0] = dd_ff[0];
            dr_in[1] = dd_ff[1];
            dr_in[2] = dd_ff[2];
         end
         SelX: begin
            dr_in[0] = dd_ff[0];
            dr_in[1] = dd_ff[3];
            dr_in[2] = dd_ff[4];
         end
         SelY: begin
            dr_in[0] = dd_ff[1];
            dr_in[1] = dd_ff[3];
            dr_in[2] = dd_ff[5];
         end
         SelZ: begin
            dr_in[0] = dd_ff[2];
            dr_in[1] = dd_ff[4];
            dr_in[2] = dd_ff[5];
         end
         default: begin
            dr_in[0] = dd_ff[0];
            dr_in[1] = dd_ff[1];
            dr_in[2] = dd_ff[2];
         end
      endcase
   end

   // Trace terms sum to zero, so the largest is never negative.
   always_ff @(posedge clock) begin
      if (adv) begin
         rt2_ff[StSelect].v <= ({31'd0, big} + Q30One) << 28;
         rt2_ff[StSelect].r <= '0;
         sel_ff[StSelect]   <= sel;
         dr_ff[StSelect]    <= dr_in;
      end
   end

   for (genvar s = StSelect + 1; s <= StDv2Last; s++) begin : g_sel
      always_ff @(posedge clock) begin
         if (adv) begin
            sel_ff[s] <= sel_ff[s-1];
         end
      end
   end

   // Largest component root, one result bit per stage.
   for (genvar s = StRt2First; s <= StRt2Last; s++) begin : g_rt2
      always_ff @(posedge clock) begin
         if (adv) begin
            rt2_ff[s] <= root_step(rt2_ff[s-1], 5'(Root2Steps - 1 - (s - StRt2First)));
            dr_ff[s]  <= dr_ff[s-1];
         end
      end
   end

   // Other components: |d| * 2^28 / bv, one quotient bit per stage.
   for (genvar s = StDv2First; s <= StDv2Last; s++) begin : g_dv2
      always_ff @(posedge clock) begin
         if (adv) begin
            if (s == StDv2First) begin
               bv_ff[s] <= rt2_ff[StRt2Last].r[30:0];
            end else begin
               bv_ff[s] <= bv_ff[s-1];
            end
            for (int k = 0; k < 3; k++) begin
               if (s == StDv2First) begin
                  dv2_ff[s][k]  <= quo_step('{rem: {3'b0, mag32(dr_ff[StRt2Last][k][31:0]) |
                                                   {dr_ff[StRt2Last][k][32] &
                                                    !dr_ff[StRt2Last][k][31], 31'd0}, 28'd0},
                                              q: '0},
                                            rt2_ff[StRt2Last].r[31:0], 5'(QuoBits - 1));
                  neg2_ff[s][k] <= dr_ff[StRt2Last][k][32];
               end else begin
                  dv2_ff[s][k]  <= quo_step(dv2_ff[s-1][k], {1'b0, bv_ff[s-1]},
                                            5'(QuoBits - 1 - (s - StDv2First)));
                  neg2_ff[s][k] <= neg2_ff[s-1][k];
               end
            end
         end
      end
   end

   // Round to Q1.16 and place components by the selected case.
   always_comb begin
      qb  = q30_round(1'b0, bv_ff[StDv2Last]);
      qa0 = q30_round(neg2_ff[StDv2Last][0], dv2_ff[StDv2Last][0].q);
      qa1 = q30_round(neg2_ff[StDv2Last][1], dv2_ff[StDv2Last][1].q);
      qa2 = q30_round(neg2_ff[StDv2Last][2], dv2_ff[StDv2Last][2].q);
      degen_in = (side_ff[StDv2Last].len[0] == 32'd0) ||
                 (side_ff[StDv2Last].len[1] == 32'd0) ||
                 (side_ff[StDv2Last].len[2] == 32'd0);
      unique case (sel_ff[StDv2Last])
         SelW: begin
            qx_in = qa0; qy_in = qa1; qz_in = qa2; qw_in = qb;
         end
         SelX: begin
            qx_in = qb;  qy_in = qa1; qz_in = qa2; qw_in = qa0;
         end
         SelY: begin
            qx_in = qa1; qy_in = qb;  qz_in = qa2; qw_in = qa0;
         end
         SelZ: begin
            qx_in = qa1; qy_in = qa2; qz_in = qb;  qw_in = qa0;
         end
         default: begin
            qx_in = qa0; qy_in = qa1; qz_in = qa2; qw_in = qb;
         end
      endcase
      // Drop the quotients of a zero column; emit the identity.
      if (degen_in) begin
         qx_in = '0;
         qy_in = '0;
         qz_in = '0;
         qw_in = QuatOne;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff    <= qx_in;
         qy_ff    <= qy_in;
         qz_ff    <= qz_in;
         qw_ff    <= qw_in;
         degen_ff <= degen_in;
         pos_ff   <= side_ff[StDv2Last].t;
         for (int c = 0; c < Cols; c++) begin
            scale_ff[c] <= side_ff[StDv2Last].len[c][31] ? ScaleMax
                                                         : side_ff[StDv2Last].len[c][30:0];
         end
      end
   end

   assign rsp_chan.pos_x      = pos_ff[0];
   assign rsp_chan.pos_y      = pos_ff[1];
   assign rsp_chan.pos_z      = pos_ff[2];
   assign rsp_chan.quat_x     = qx_ff;
   assign rsp_chan.quat_y     = qy_ff;
   assign rsp_chan.quat_z     = qz_ff;
   assign rsp_chan.quat_w     = qw_ff;
   assign rsp_chan.scale_x    = scale_ff[0];
   assign rsp_chan.scale_y    = scale_ff[1];
   assign rsp_chan.scale_z    = scale_ff[2];
   assign rsp_chan.degenerate = degen_ff;

   `AMD_ASSERT_NOW(a_degen_identity, clock, reset, rsp_chan.valid && rsp_chan.degenerate, rsp_chan.quat_w == QuatOne && rsp_chan.quat_x == 18'sd0 && rsp_chan.quat_y == 18'sd0 && rsp_chan.quat_z == 18'sd0)
   `AMD_ASSERT_NOW(a_scale_nonzero, clock, reset, rsp_chan.valid && !rsp_chan.degenerate, rsp_chan.scale_x != 31'd0 && rsp_chan.scale_y != 31'd0 && rsp_chan.scale_z != 31'd0)
   `AMD_ASSERT_NOW(a_ready_when_free, clock, reset, !vld_ff[StOut], req_chan.ready)
   `AMD_ASSERT_NEXT(a_accept_enters, clock, reset, req_chan.valid && req_chan.ready, vld_ff[StSq])

endmodule
`default_nettype wire

/* tb/amd_decompose_checker.sv */
// Checker: predicts each decomposition from the accepted matrix and compares the responses.
`default_nettype none
module amd_decompose_checker import amd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   amd_req_if        req_chan,
   amd_rsp_if        rsp_chan,
   output int        fail_count,
   output int        pending_count
);

   typedef logic [10:0][31:0] field_set_type;

   field_set_type decomp_queue[$];
   string      field_name[11] = '{"pos_x", "pos_y", "pos_z", "quat_x", "quat_y", "quat_z",
                                  "quat_w", "scale_x", "scale_y", "scale_z", "degenerate"};

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [17:0] to_q16(longint v);
      longint m;
      m = ((v < 0 ? -v : v) + 8192) >>> 14;
      return (v < 0) ? 18'(-m) : 18'(m);
   endfunction

   // Work out position, scale and quaternion of one matrix transaction.
   function automatic field_set_type decompose(logic signed [11:0][31:0] e);
      longint     col[3][3];
      longint     len[3];
      longint     nrm[3][3];
      longint     q[4];
      longint     fw, fx, fy, fz, big, bv;
      logic [63:0] sum;
      sel_type    sel;
      logic       degen;
      field_set_type f;
      degen = 1'b0;
      for (int c = 0; c < 3; c++) begin
         sum = 0;
         for (int r = 0; r < 3; r++) begin
            col[c][r] = longint'($signed(e[c*3+r]));
            sum = sum + 64'(col[c][r] * col[c][r]);
         end
         len[c] = longint'(int_sqrt(sum));
         if (len[c] == 0) degen = 1'b1;
      end
      if (degen) begin
         q[0] = 0; q[1] = 0; q[2] = 0; q[3] = 64'd1 << 30;
      end else begin
         for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
               nrm[c][r] = (col[c][r] * (longint'(1) << 30)) / len[c];
         fx = nrm[0][0] - nrm[1][1] - nrm[2][2];
         fy = nrm[1][1] - nrm[0][0] - nrm[2][2];
         fz = nrm[2][2] - nrm[0][0] - nrm[1][1];
         fw = nrm[0][0] + nrm[1][1] + nrm[2][2];
         big = fw;
         sel = SelW;
         // strict compares: ties stay with the earlier choice
         if (fx > big) begin big = fx; sel = SelX; end
         if (fy > big) begin big = fy; sel = SelY; end
         if (fz > big) begin big = fz; sel = SelZ; end
         bv = longint'(int_sqrt(64'(big + (longint'(1) << 30)) << 28));
         case (sel)
            SelW: begin
               q[3] = bv;
               q[0] = ((nrm[1][2] - nrm[2][1]) * 268435456) / bv;
               q[1] = ((nrm[2][0] - nrm[0][2]) * 268435456) / bv;
               q[2] = ((nrm[0][1] - nrm[1][0]) * 268435456) / bv;
            end
            SelX: begin
               q[0] = bv;
               q[3] = ((nrm[1][2] - nrm[2][1]) * 268435456) / bv;
               q[1] = ((nrm[0][1] + nrm[1][0]) * 268435456) / bv;
               q[2] = ((nrm[2][0] + nrm[0][2]) * 268435456) / bv;
            end
            SelY: begin
               q[1] = bv;
               q[3] = ((nrm[2][0] - nrm[0][2]) * 268435456) / bv;
               q[0] = ((nrm[0][1] + nrm[1][0]) * 268435456) / bv;
               q[2] = ((nrm[1][2] + nrm[2][1]) * 268435456) / bv;
            end
            default: begin
               q[2] = bv;
               q[3] = ((nrm[0][1] - nrm[1][0]) * 268435456) / bv;
               q[0] = ((nrm[2][0] + nrm[0][2]) * 268435456) / bv;
               q[1] = ((nrm[1][2] + nrm[2][1]) * 268435456) / bv;
            end
         endcase
      end
      f[0] = e[9];
      f[1] = e[10];
      f[2] = e[11];
      for (int c = 0; c < 4; c++) f[3+c] = {14'd0, to_q16(q[c])};
      for (int c = 0; c < 3; c++)
         f[7+c] = (len[c] > longint'(ScaleMax)) ? {1'b0, ScaleMax} : 32'(len[c]);
      f[10] = {31'd0, degen};
      return f;
   endfunction

   assign pending_count = decomp_queue.size();

   always @(posedge clock) begin
      field_set_type exp_f;
      field_set_type act_f;
      logic       bad;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            decomp_queue.push_back(decompose({req_chan.t_z, req_chan.t_y, req_chan.t_x,
               req_chan.c2_z, req_chan.c2_y, req_chan.c2_x, req_chan.c1_z, req_chan.c1_y,
               req_chan.c1_x, req_chan.c0_z, req_chan.c0_y, req_chan.c0_x}));
         if (rsp_chan.valid && rsp_chan.ready) begin
            act_f = {31'd0, rsp_chan.degenerate, 1'b0, rsp_chan.scale_z,
                     1'b0, rsp_chan.scale_y, 1'b0, rsp_chan.scale_x,
                     14'd0, rsp_chan.quat_w, 14'd0, rsp_chan.quat_z,
                     14'd0, rsp_chan.quat_y, 14'd0, rsp_chan.quat_x,
                     rsp_chan.pos_z, rsp_chan.pos_y, rsp_chan.pos_x};
            if (decomp_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected response transaction");
               fail_count <= fail_count + 1;
            end else begin
               exp_f = decomp_queue.pop_front();
               bad = 1'b0;
               for (int i = 0; i < 11; i++)
                  if (exp_f[i] !== act_f[i]) begin
                     bad = 1'b1;
                     if (fail_count < 10)
                        $display("mismatch %s: expected %h actual %h",
                                 field_name[i], exp_f[i], act_f[i]);
                  end
               if (bad) fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule
`default_nettype wire

/* tb/affine_matrix_decompose_top_test.sv */
// Testbench top: matrix stimulus, response flow control and the verdict.
`default_nettype none
module affine_matrix_decompose_top_test;
   import amd_pkg::*;

   localparam int RandomItems = 1730;
   localparam int TailItems   = 200;   // no idling in the last part of the run
   localparam int WatchLimit  = 5000;
   localparam int LongHold    = 400;   // longer than the 130 stages, so the input stalls
   localparam logic signed [31:0] One  = 32'sd65536;
   localparam logic signed [31:0] MaxV = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MinV = 32'sh8000_0000;

   typedef logic signed [11:0][31:0] matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   sent_count = 0;
   int   total_items;
   int   quiet_cycles = 0;
   logic sending_done = 1'b0;

   amd_req_if req_chan();
   amd_rsp_if rsp_chan();

   affine_matrix_decompose_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   amd_decompose_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #6 clock = ~clock;

   // Hold the request channel on one matrix until a transaction completes.
   task automatic send_matrix(matrix_type e, logic may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      {req_chan.t_z, req_chan.t_y, req_chan.t_x, req_chan.c2_z, req_chan.c2_y,
       req_chan.c2_x, req_chan.c1_z, req_chan.c1_y, req_chan.c1_x, req_chan.c0_z,
       req_chan.c0_y, req_chan.c0_x} <= e;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   // Pick a component by mode: any value, Q16.16 values within two of zero, or small Q16.16 noise.
   function automatic logic signed [31:0] pick_entry(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(0, 262144)) - 131072;
         default: return $signed($urandom_range(0, 2047)) - 1024;
      endcase
   endfunction

   // Build a random matrix: noisy scaled signed permutations dominate, so every
   // largest-component branch is taken, with raw and degenerate matrices mixed in.
   function automatic matrix_type random_matrix();
      matrix_type e;
      int      kind;
      int      perm[3];
      int      tmp, j;
      logic signed [31:0] s;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 12; i++) e[i] = pick_entry(kind < 3 ? 0 : 2);
      perm = '{0, 1, 2};
      for (int i = 2; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
      end
      if (kind >= 3 && kind < 8) begin
         for (int c = 0; c < 3; c++) begin
            s = $urandom_range(0, 3) == 0 ? pick_entry(1) + One : One;
            e[c*3 + perm[c]] = $urandom_range(0, 1) ? s : -s;
         end
      end else if (kind == 8) begin
         for (int i = 0; i < 9; i++) e[i] = pick_entry(1);
      end
      if ($urandom_range(0, 24) == 0) begin
         tmp = $urandom_range(0, 2);
         for (int r = 0; r < 3; r++) e[tmp*3 + r] = 0;
      end
      for (int i = 9; i < 12; i++) e[i] = $urandom();
      return e;
   endfunction

   // Stimulus: directed corner matrices, then random ones.
   initial begin
      matrix_type directed[$];
      req_chan.valid = 1'b0;
      {req_chan.t_z, req_chan.t_y, req_chan.t_x, req_chan.c2_z, req_chan.c2_y,
       req_chan.c2_x, req_chan.c1_z, req_chan.c1_y, req_chan.c1_x, req_chan.c0_z,
       req_chan.c0_y, req_chan.c0_x} = '0;
      // identity, translation extremes
      directed.push_back({32'sd0, 32'sd0, 32'sd0, One, 32'sd0, 32'sd0,
                          32'sd0, One, 32'sd0, 32'sd0, 32'sd0, One});
      directed.push_back({-32'sd1, MinV, MaxV, One, 32'sd0, 32'sd0,
                          32'sd0, One, 32'sd0, 32'sd0, 32'sd0, One});
      // half turns: x, y and z become the largest component
      directed.push_back({96'd0, -One, 32'sd0, 32'sd0, 32'sd0, -One, 32'sd0,
                          32'sd0, 32'sd0, One});
      directed.push_back({96'd0, -One, 32'sd0, 32'sd0, 32'sd0, One, 32'sd0,
                          32'sd0, 32'sd0, -One});
      directed.push_back({96'd0, One, 32'sd0, 32'sd0, 32'sd0, -One, 32'sd0,
                          32'sd0, 32'sd0, -One});
      // quarter turn about z
      directed.push_back({96'd0, One, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -One,
                          32'sd0, One, 32'sd0});
      // zero column, all zero
      directed.push_back({32'sd5, 32'sd6, 32'sd7, One, 32'sd0, 32'sd0,
                          32'sd0, One, 32'sd0, 96'd0});
      directed.push_back({12{32'sd0}});
      // oversized columns saturate the scale
      directed.push_back({12{MinV}});
      directed.push_back({12{MaxV}});
      directed.push_back({96'd0, MinV, 32'sd0, 32'sd0, 32'sd0, MaxV, 32'sd0,
                          32'sd0, 32'sd0, 32'sd1});
      // non-uniform scale
      directed.push_back({96'd0, 32'sd131072, 32'sd0, 32'sd0, 32'sd0, 32'sd32768,
                          32'sd0, 32'sd0, 32'sd0, 32'sd196608});
      // tie between w and x stays with w
      directed.push_back({96'd0, 32'sd0, One, 32'sd0, One, 32'sd0, 32'sd0,
                          32'sd0, 32'sd0, One});
      // non-orthogonal, smallest nonzero entries
      directed.push_back({96'd0, {9{One}}});
      directed.push_back({96'd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, -32'sd1, 32'sd0,
                          32'sd0, 32'sd0, 32'sd1});
      directed.push_back({96'd0, -One, -One, One, One, -One, One, -One, One, One});
      total_items = directed.size() + RandomItems;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_matrix(directed[i], 1'b1);
      for (int n = 0; n < RandomItems; n++) begin
         // pause once until every expected response has come back
         if (n == 800) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            while (pending_count != 0) @(posedge clock);
         end
         send_matrix(random_matrix(), sent_count < total_items - TailItems);
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;
      sending_done <= 1'b1;
   end

   // Response flow control: random stall bursts and one long hold.
   initial begin
      logic long_done;
      long_done = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_done && sent_count >= 400) begin
            long_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (LongHold - 1) @(negedge clock);
         end else if (sent_count < total_items - TailItems && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("affine_matrix_decompose_top regression: fail");
         $finish;
      end
   end

   // Drain, allow for the pipeline latency, then give the verdict.
   initial begin
      wait (sending_done);
      while (pending_count != 0) @(posedge clock);
      repeat (140) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("affine_matrix_decompose_top regression: pass");
      else
         $display("affine_matrix_decompose_top regression: fail");
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/amd_pkg.sv
rtl/amd_if.sv
rtl/affine_matrix_decompose_top.sv
tb/amd_decompose_checker.sv
tb/affine_matrix_decompose_top_test.sv
